FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers shared by the page buffer directory modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Clocked check, quiet while reset is held.
`define PBD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Clocked check that also holds during reset.
`define PBD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define PBD_ASSERT(lbl, clk, rst_n, prop, msg)
`define PBD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: design/pbd_pkg.sv
// ----------------------------------------------------------------------------
// pbd_pkg
// Types and constants of the page buffer directory.
// ----------------------------------------------------------------------------
package pbd_pkg;

    localparam logic [31:0] EMPTY_PAGE = 32'hFFFF_FFFF;
    localparam logic [3:0]  MIN_SLOTS  = 4'd2;
    localparam logic [3:0]  CFG_RESET  = 4'd8;

    typedef enum logic [2:0] {
        CMD_READ  = 3'd0,
        CMD_WRITE = 3'd1,
        CMD_DIRTY = 3'd2,
        CMD_EVICT = 3'd3,
        CMD_CLEAR = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PICK,
        S_LEVEL,
        S_COMMIT
    } t_state;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] page_num;
        logic [31:0] root_page_id;
        logic [2:0]  slot;
        logic [2:0]  level;
    } t_req;

    typedef struct packed {
        logic [2:0]  out_slot;
        logic        hit;
        logic        fetch;
        logic        writeback;
        logic [2:0]  writeback_level;
        logic [31:0] new_page_id;
        logic [31:0] read_count;
        logic [31:0] hit_count;
        logic [31:0] write_count;
    } t_rsp;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic pick;
        logic commit;
    } t_ctl;

    // Datapath to controller
    typedef struct packed {
        logic req_scan;
        logic is_read;
        logic scan_done;
        logic out_free;
    } t_sts;

endpackage

FILE: design/pbd_in_if.sv
// ----------------------------------------------------------------------------
// pbd_in_if
// Command channel: valid/ready handshake carrying one request word.
// ----------------------------------------------------------------------------
interface pbd_in_if;
    logic          valid;
    logic          ready;
    pbd_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: design/pbd_out_if.sv
// ----------------------------------------------------------------------------
// pbd_out_if
// Result channel: valid/ready handshake carrying one response word.
// ----------------------------------------------------------------------------
interface pbd_out_if;
    logic          valid;
    logic          ready;
    pbd_pkg::t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: design/pbd_ctrl.sv
// ----------------------------------------------------------------------------
// pbd_ctrl
// Sequencer for one command: load, tag scan (read, evict), slot pick and level read (read only), commit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pbd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  pbd_pkg::t_sts i_sts,
    output pbd_pkg::t_ctl o_ctl
);

    pbd_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pbd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_ctl       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            pbd_pkg::S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_ctl.load = 1'b1;
                    n_state    = i_sts.req_scan ? pbd_pkg::S_SCAN : pbd_pkg::S_COMMIT;
                end
            end
            pbd_pkg::S_SCAN: begin
                o_ctl.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = i_sts.is_read ? pbd_pkg::S_PICK : pbd_pkg::S_COMMIT;
                end
            end
            pbd_pkg::S_PICK: begin
                o_ctl.pick = 1'b1;
                n_state    = pbd_pkg::S_LEVEL;
            end
            pbd_pkg::S_LEVEL: begin
                n_state = pbd_pkg::S_COMMIT;
            end
            pbd_pkg::S_COMMIT: begin
                if (i_sts.out_free) begin
                    o_ctl.commit = 1'b1;
                    n_state      = pbd_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pbd_pkg::S_IDLE;
            end
        endcase
    end

    `PBD_ASSERT(a_commit_free, i_clk, i_rst_n, o_ctl.commit |-> i_sts.out_free, "commit with output busy")
    `PBD_ASSERT(a_one_cmd, i_clk, i_rst_n, $onehot0(o_ctl), "more than one datapath command")
    `PBD_ASSERT(a_level_after_pick, i_clk, i_rst_n, (r_state == pbd_pkg::S_LEVEL) |-> ($past(r_state) == pbd_pkg::S_PICK), "level read without pick")

endmodule

FILE: design/pbd_datapath.sv
// ----------------------------------------------------------------------------
// pbd_datapath
// Slot tag and level memories, dirty and valid bits, scan accumulators,
// victim choice, counters and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pbd_datapath #(
    parameter int MAX_SLOTS = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [3:0]    i_nslots,
    input  pbd_pkg::t_req i_req_data,
    input  pbd_pkg::t_ctl i_ctl,
    output pbd_pkg::t_sts o_sts,
    output logic          o_rsp_valid,
    output pbd_pkg::t_rsp o_rsp_data,
    input  logic          i_rsp_ready
);

    localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int IW     = (SLOT_W > 4) ? SLOT_W : 4;

    localparam logic [3:0] SLOT_ROOT  = 4'd1;
    localparam logic [3:0] SLOT_BASE  = 4'd2;
    localparam logic [3:0] SLOTS_THREE = 4'd3;

    function automatic logic [SLOT_W-1:0] to_idx(input logic [3:0] v);
        logic [IW-1:0] w;
        w = IW'(v);
        return w[SLOT_W-1:0];
    endfunction

    // Held request
    logic [2:0]  r_cmd;
    logic [31:0] r_page;
    logic [31:0] r_root;
    logic [2:0]  r_slot;
    logic [2:0]  r_level;

    // Slot state
    logic [31:0]          r_page_mem [MAX_SLOTS];
    logic [2:0]           r_lvl_mem  [MAX_SLOTS];
    logic [MAX_SLOTS-1:0] r_valid;
    logic [MAX_SLOTS-1:0] r_dirty;
    logic [31:0]          r_last_hit;
    logic [3:0]           r_vp;
    logic [31:0]          r_nwp;
    logic [31:0]          r_reads;
    logic [31:0]          r_hits;
    logic [31:0]          r_writes;

    // Scan pipeline
    logic [3:0]  r_cnt;
    logic        r_cmp_vld;
    logic [3:0]  r_cmp_idx;
    logic [31:0] r_rd_page;
    logic        r_rd_valid;
    logic [31:0] w_eff;

    // Scan results
    logic       r_hit_f, r_ev_f, r_emp_f, r_rs_f, r_r2_f;
    logic [3:0] r_hit_idx, r_ev_idx, r_emp_idx, r_rs_idx, r_r2_idx;

    // Pick
    logic [3:0] r_sel, w_sel;
    logic       r_sel_hit, w_sel_hit;
    logic [3:0] n_vp;
    logic [2:0] r_lvl_q;

    // Commit
    logic              w_slot_ok;
    logic [SLOT_W-1:0] w_upd_idx;
    logic              w_pg_we, w_lv_we;
    logic [31:0]       w_pg_wdata;
    logic              w_vld_set, w_vld_clr, w_dty_set, w_dty_clr, w_hit_upd;
    logic [31:0]       n_nwp, n_reads, n_hits, n_writes;
    pbd_pkg::t_rsp     w_rsp;

    logic          r_out_vld;
    pbd_pkg::t_rsp r_out;

    assign w_eff = r_rd_valid ? r_rd_page : pbd_pkg::EMPTY_PAGE;

    assign o_sts.req_scan  = i_req_data.cmd inside {pbd_pkg::CMD_READ, pbd_pkg::CMD_EVICT};
    assign o_sts.is_read   = (r_cmd == pbd_pkg::CMD_READ);
    assign o_sts.scan_done = r_cmp_vld && (r_cmp_idx == (i_nslots - 4'd1));
    assign o_sts.out_free  = !r_out_vld || i_rsp_ready;

    assign o_rsp_valid = r_out_vld;
    assign o_rsp_data  = r_out;

    // Request capture
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd   <= i_req_data.cmd;
            r_page  <= i_req_data.page_num;
            r_root  <= i_req_data.root_page_id;
            r_slot  <= i_req_data.slot;
            r_level <= i_req_data.level;
        end
    end

    // Memories: one write, registered reads at the scan and the chosen slot
    always_ff @(posedge i_clk) begin
        if (i_ctl.commit && w_pg_we) begin
            r_page_mem[w_upd_idx] <= w_pg_wdata;
        end
        if (i_ctl.commit && w_lv_we) begin
            r_lvl_mem[w_upd_idx] <= r_level;
        end
        r_rd_page <= r_page_mem[to_idx(r_cnt)];
        r_lvl_q   <= r_lvl_mem[to_idx(r_sel)];
    end

    // Scan result indexes and pick result
    always_ff @(posedge i_clk) begin
        if (i_ctl.scan && r_cmp_vld) begin
            if (!r_hit_f) r_hit_idx <= r_cmp_idx;
            if (!r_ev_f)  r_ev_idx  <= r_cmp_idx;
            if (!r_emp_f) r_emp_idx <= r_cmp_idx;
            if (!r_rs_f)  r_rs_idx  <= r_cmp_idx;
            if (!r_r2_f)  r_r2_idx  <= r_cmp_idx;
        end
        if (i_ctl.pick) begin
            r_sel     <= w_sel;
            r_sel_hit <= w_sel_hit;
        end
    end

    // Victim choice for a read
    always_comb begin
        w_sel     = SLOT_BASE;
        w_sel_hit = 1'b0;
        n_vp      = r_vp;
        if (r_hit_f) begin
            w_sel     = r_hit_idx;
            w_sel_hit = 1'b1;
        end else if ((i_nslots == pbd_pkg::MIN_SLOTS) || (r_root == r_page)) begin
            w_sel = SLOT_ROOT;
        end else if (i_nslots == SLOTS_THREE) begin
            w_sel = SLOT_BASE;
        end else if (r_emp_f) begin
            w_sel = r_emp_idx;
        end else if ((r_vp < i_nslots) && r_rs_f) begin
            w_sel = r_rs_idx;
            n_vp  = r_vp + 4'd1;
        end else begin
            // pointer wrapped: restart the round at the base slot
            w_sel = r_r2_f ? r_r2_idx : SLOT_BASE;
            n_vp  = SLOT_BASE;
        end
    end

    // Commit decode
    always_comb begin
        w_rsp      = '0;
        w_slot_ok  = ({1'b0, r_slot} < i_nslots);
        w_upd_idx  = to_idx({1'b0, r_slot});
        w_pg_we    = 1'b0;
        w_lv_we    = 1'b0;
        w_pg_wdata = r_page;
        w_vld_set  = 1'b0;
        w_vld_clr  = 1'b0;
        w_dty_set  = 1'b0;
        w_dty_clr  = 1'b0;
        w_hit_upd  = 1'b0;
        n_nwp      = r_nwp;
        n_reads    = r_reads;
        n_hits     = r_hits;
        n_writes   = r_writes;
        unique case (r_cmd)
            pbd_pkg::CMD_READ: begin
                w_upd_idx      = to_idx(r_sel);
                w_rsp.out_slot = r_sel[2:0];
                if (r_sel_hit) begin
                    w_rsp.hit = 1'b1;
                    w_hit_upd = 1'b1;
                    n_hits    = r_hits + 32'd1;
                end else begin
                    if (r_dirty[to_idx(r_sel)]) begin
                        w_rsp.writeback       = 1'b1;
                        w_rsp.writeback_level = r_lvl_q;
                        w_rsp.new_page_id     = r_nwp;
                        n_nwp                 = r_nwp + 32'd1;
                        n_writes              = r_writes + 32'd1;
                    end
                    w_pg_we     = 1'b1;
                    w_vld_set   = 1'b1;
                    w_dty_clr   = 1'b1;
                    n_reads     = r_reads + 32'd1;
                    w_rsp.fetch = 1'b1;
                end
            end
            pbd_pkg::CMD_WRITE: begin
                if (w_slot_ok) begin
                    w_rsp.out_slot    = r_slot;
                    w_rsp.writeback   = 1'b1;
                    w_rsp.new_page_id = r_nwp;
                    w_pg_we           = 1'b1;
                    w_pg_wdata        = r_nwp;
                    w_vld_set         = 1'b1;
                    w_dty_clr         = 1'b1;
                    n_nwp             = r_nwp + 32'd1;
                    n_writes          = r_writes + 32'd1;
                end
            end
            pbd_pkg::CMD_DIRTY: begin
                if (w_slot_ok) begin
                    w_rsp.out_slot = r_slot;
                    w_dty_set      = 1'b1;
                    w_lv_we        = 1'b1;
                end
            end
            pbd_pkg::CMD_EVICT: begin
                w_upd_idx = to_idx(r_ev_idx);
                if (r_ev_f) begin
                    w_rsp.out_slot = r_ev_idx[2:0];
                    w_vld_clr      = 1'b1;
                    w_dty_clr      = 1'b1;
                end
            end
            pbd_pkg::CMD_CLEAR: begin
                n_reads  = '0;
                n_hits   = '0;
                n_writes = '0;
            end
            default: begin
            end
        endcase
        w_rsp.read_count  = n_reads;
        w_rsp.hit_count   = n_hits;
        w_rsp.write_count = n_writes;
    end

    // Control state, slot bits, counters and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_dirty    <= '0;
            r_last_hit <= '0;
            r_vp       <= 4'd1;
            r_nwp      <= '0;
            r_reads    <= '0;
            r_hits     <= '0;
            r_writes   <= '0;
            r_cnt      <= '0;
            r_cmp_vld  <= 1'b0;
            r_rd_valid <= 1'b0;
            r_hit_f    <= 1'b0;
            r_ev_f     <= 1'b0;
            r_emp_f    <= 1'b0;
            r_rs_f     <= 1'b0;
            r_r2_f     <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_rd_valid <= r_valid[to_idx(r_cnt)];
            if (i_ctl.load) begin
                r_cnt     <= '0;
                r_cmp_vld <= 1'b0;
                r_hit_f   <= 1'b0;
                r_ev_f    <= 1'b0;
                r_emp_f   <= 1'b0;
                r_rs_f    <= 1'b0;
                r_r2_f    <= 1'b0;
            end
            if (i_ctl.scan) begin
                // issue the next tag read, compare the one issued last cycle
                if (r_cnt < i_nslots) begin
                    r_cnt     <= r_cnt + 4'd1;
                    r_cmp_vld <= 1'b1;
                    r_cmp_idx <= r_cnt;
                end else begin
                    r_cmp_vld <= 1'b0;
                end
                if (r_cmp_vld) begin
                    if ((r_cmp_idx != '0) && (w_eff == r_page)) r_hit_f <= 1'b1;
                    if (w_eff == r_page) r_ev_f <= 1'b1;
                    if ((r_cmp_idx >= SLOT_BASE) && (w_eff == pbd_pkg::EMPTY_PAGE)) begin
                        r_emp_f <= 1'b1;
                    end
                    if ((r_cmp_idx >= r_vp) && (w_eff != r_last_hit)) r_rs_f <= 1'b1;
                    if ((r_cmp_idx >= SLOT_BASE) && (w_eff != r_last_hit)) r_r2_f <= 1'b1;
                end
            end
            if (i_ctl.pick) begin
                r_vp <= n_vp;
            end
            if (i_ctl.commit) begin
                if (w_vld_set) r_valid[w_upd_idx] <= 1'b1;
                if (w_vld_clr) r_valid[w_upd_idx] <= 1'b0;
                if (w_dty_set) r_dirty[w_upd_idx] <= 1'b1;
                if (w_dty_clr) r_dirty[w_upd_idx] <= 1'b0;
                if (w_hit_upd) r_last_hit <= r_page;
                r_nwp     <= n_nwp;
                r_reads   <= n_reads;
                r_hits    <= n_hits;
                r_writes  <= n_writes;
                r_out_vld <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.commit) begin
            r_out <= w_rsp;
        end
    end

    `PBD_ASSERT(a_hit_not_slot0, i_clk, i_rst_n, r_hit_f |-> (r_hit_idx != 4'd0), "hit found in reserved slot")
    `PBD_ASSERT(a_empty_from_base, i_clk, i_rst_n, r_emp_f |-> (r_emp_idx >= SLOT_BASE), "empty slot below base")
    `PBD_ASSERT(a_pick_in_range, i_clk, i_rst_n, i_ctl.pick |=> (r_sel < i_nslots), "chosen slot out of range")

endmodule

FILE: design/page_buffer_directory.sv
// ----------------------------------------------------------------------------
// page_buffer_directory
// Directory of a small page buffer: slot tags, dirty marks with path level,
// victim choice on a read miss, write-page numbering and usage counters.
// ----------------------------------------------------------------------------
//
//   channel   dir  handshake               word
//   i_req     in   valid/ready             cmd, page_num, root_page_id, slot, level
//   o_rsp     out  valid/ready             out_slot, hit, fetch, writeback, ...
//   apb       in   psel/penable/pready     slots_in_use at byte address 0
//
// A read or an evict walks the slot tag memory through its single read port,
// one slot per cycle; the write, dirty and clear commands skip the scan.
// One command is in flight at a time; the next is accepted once the result
// sits in the output register, even while that result is still stalled.
// Reset (synchronous, active low) empties every slot at once through the
// per-slot valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
module page_buffer_directory #(
    parameter int MAX_SLOTS = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    pbd_in_if.sink       i_req,
    pbd_out_if.source    o_rsp,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    // The slot count register is 4 bits, so no more than 15 slots are usable.
    localparam int NCAP = (MAX_SLOTS > 15) ? 15 : MAX_SLOTS;

    logic [3:0]    r_cfg;
    logic [3:0]    w_nslots;
    logic          w_cfg_sel;
    logic          w_req_ready;
    pbd_pkg::t_ctl w_ctl;
    pbd_pkg::t_sts w_sts;

    // Configuration port: zero wait states, register 0 decoded on paddr[2].
    assign pready    = 1'b1;
    assign w_cfg_sel = (paddr[2] == 1'b0);
    assign prdata    = w_cfg_sel ? {28'd0, r_cfg} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= pbd_pkg::CFG_RESET;
        end else if (psel && penable && pwrite && w_cfg_sel) begin
            r_cfg <= pwdata[3:0];
        end
    end

    // Clamp the slot count into the usable range.
    always_comb begin
        if (r_cfg < pbd_pkg::MIN_SLOTS) begin
            w_nslots = pbd_pkg::MIN_SLOTS;
        end else if (32'(r_cfg) > NCAP) begin
            w_nslots = 4'(NCAP);
        end else begin
            w_nslots = r_cfg;
        end
    end

    assign i_req.ready = w_req_ready;

    // Sequencer: steps each command through load and commit, with a scan for a read or an evict and a pick for a read.
    pbd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (w_req_ready),
        .i_sts       (w_sts),
        .o_ctl       (w_ctl)
    );

    // Slot state, scan compare, victim choice and the result word.
    pbd_datapath #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_nslots    (w_nslots),
        .i_req_data  (i_req.data),
        .i_ctl       (w_ctl),
        .o_sts       (w_sts),
        .o_rsp_valid (o_rsp.valid),
        .o_rsp_data  (o_rsp.data),
        .i_rsp_ready (o_rsp.ready)
    );

endmodule
